### rtl/fixnum_alu_with_overflow_unit_defines.svh
// ---------------------------------------------------------------------------
// Fixnum ALU assertion macros
// Shared concurrent assertion forms, clocked on clock, off during reset.
// ---------------------------------------------------------------------------
`ifndef FIXNUM_ALU_WITH_OVERFLOW_UNIT_DEFINES_SVH
`define FIXNUM_ALU_WITH_OVERFLOW_UNIT_DEFINES_SVH

// same-cycle implication
`define FXA_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define FXA_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/fxa_pkg.sv
// ---------------------------------------------------------------------------
// Fixnum ALU package
// Beat types, opcodes and shared helpers.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package fxa_pkg;

   typedef enum logic [3:0] {
      OP_ADD      = 4'd0,
      OP_SUB      = 4'd1,
      OP_MUL      = 4'd2,
      OP_FLOORDIV = 4'd3,
      OP_REM      = 4'd4,
      OP_CMP      = 4'd5,
      OP_EQ       = 4'd6,
      OP_LT       = 4'd7,
      OP_LE       = 4'd8,
      OP_GT       = 4'd9,
      OP_GE       = 4'd10,
      OP_AND      = 4'd11,
      OP_OR       = 4'd12,
      OP_NOT      = 4'd13,
      OP_NEG      = 4'd14,
      OP_ABS      = 4'd15
   } opcode_type;

   localparam logic CSR_PRODUCT_MIN = 1'b0;
   localparam logic CSR_PRODUCT_MAX = 1'b1;

   typedef struct packed {
      logic [3:0]         opcode;
      logic signed [63:0] operand_a;
      logic signed [63:0] operand_b;
   } req_type;

   typedef struct packed {
      logic signed [63:0] result_value;
      logic               overflow;
      logic               error_code;
   } rsp_type;

   // per-beat context carried down the pipe
   typedef struct packed {
      logic [3:0]  opcode;
      logic [63:0] value;
      logic        ovf;
      logic        a_neg;
      logic        b_neg;
      logic        b_zero;
   } ctx_type;

   // keep bits [msb:0], sign-extend to 64
   function automatic logic [63:0] sext_bits(input logic [63:0] x, input logic [5:0] msb);
      logic [63:0] r;
      for (int i = 0; i < 64; i++) begin
         r[i] = (6'(i) <= msb) ? x[i] : x[msb];
      end
      return r;
   endfunction

endpackage

### rtl/fxa_front.sv
// ---------------------------------------------------------------------------
// Fixnum ALU front stage
// Operand narrowing, magnitudes, and the results of all opcodes but mul and divide.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module fxa_front #(
   parameter int DATA_BITS = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             adv,
   input  logic             in_valid,
   input  fxa_pkg::req_type req,
   output logic             out_valid,
   output fxa_pkg::ctx_type ctx,
   output logic [63:0]      ma,
   output logic [63:0]      mb
);
   import fxa_pkg::*;

   localparam logic [5:0]  MSB      = 6'(DATA_BITS - 1);
   localparam logic [63:0] SIGN_BIT = 64'd1 << (DATA_BITS - 1);
   localparam logic [63:0] MIN_VAL  = ~(SIGN_BIT - 64'd1);

   logic [63:0] a, b, sum, dif, neg_a;
   logic        lt, gt, eq, add_ovf, sub_ovf, a_min;
   logic        valid_ff;
   ctx_type     ctx_in, ctx_ff;
   logic [63:0] ma_in, mb_in, ma_ff, mb_ff;

   always_comb begin
      a       = sext_bits(req.operand_a, MSB);
      b       = sext_bits(req.operand_b, MSB);
      sum     = a + b;
      dif     = a - b;
      neg_a   = 64'd0 - a;
      lt      = $signed(a) < $signed(b);
      gt      = $signed(b) < $signed(a);
      eq      = (a == b);
      a_min   = (a == MIN_VAL);
      add_ovf = (((a ^ sum) & (b ^ sum)) >> 63) != 64'd0 || sext_bits(sum, MSB) != sum;
      sub_ovf = (((a ^ b) & (a ^ dif)) >> 63) != 64'd0 || sext_bits(dif, MSB) != dif;
      ma_in   = a[63] ? neg_a : a;
      mb_in   = b[63] ? (64'd0 - b) : b;

      ctx_in        = '0;
      ctx_in.opcode = req.opcode;
      ctx_in.a_neg  = a[63];
      ctx_in.b_neg  = b[63];
      ctx_in.b_zero = (b == 64'd0);
      case (opcode_type'(req.opcode))
         OP_ADD: begin
            ctx_in.value = sum;
            ctx_in.ovf   = add_ovf;
         end
         OP_SUB: begin
            ctx_in.value = dif;
            ctx_in.ovf   = sub_ovf;
         end
         OP_CMP: ctx_in.value = lt ? '1 : (eq ? 64'd0 : 64'd1);
         OP_EQ:  ctx_in.value = 64'(eq);
         OP_LT:  ctx_in.value = 64'(lt);
         OP_LE:  ctx_in.value = 64'(!gt);
         OP_GT:  ctx_in.value = 64'(gt);
         OP_GE:  ctx_in.value = 64'(!lt);
         OP_AND: ctx_in.value = a & b;
         OP_OR:  ctx_in.value = a | b;
         OP_NOT: ctx_in.value = ~a;
         OP_NEG: begin
            ctx_in.value = neg_a;
            ctx_in.ovf   = a_min;
         end
         OP_ABS: begin
            ctx_in.value = ma_in;
            ctx_in.ovf   = a_min;
         end
         default: ctx_in.value = 64'd0;  // mul and divide finish later
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
      if (adv) begin
         ctx_ff <= ctx_in;
         ma_ff  <= ma_in;
         mb_ff  <= mb_in;
      end
   end

   assign out_valid = valid_ff;
   assign ctx       = ctx_ff;
   assign ma        = ma_ff;
   assign mb        = mb_ff;

endmodule

### rtl/fxa_mul.sv
// ---------------------------------------------------------------------------
// Fixnum ALU multiplier
// Three stages: partial products, 128-bit sum, sign and range check.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module fxa_mul #(
   parameter int DATA_BITS = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             adv,
   input  logic [63:0]      product_min,
   input  logic [62:0]      product_max,
   input  logic             in_valid,
   input  fxa_pkg::ctx_type in_ctx,
   input  logic [63:0]      in_ma,
   input  logic [63:0]      in_mb,
   output logic             out_valid,
   output fxa_pkg::ctx_type out_ctx,
   output logic [63:0]      out_ma,
   output logic [63:0]      out_mb
);
   import fxa_pkg::*;

   localparam logic [63:0] SIGN_BIT = 64'd1 << (DATA_BITS - 1);

   logic         v1_ff, v2_ff, v3_ff;
   ctx_type      c1_ff, c2_ff, c3_ff, c3_in;
   logic [63:0]  ma1_ff, mb1_ff, ma2_ff, mb2_ff, ma3_ff, mb3_ff;
   logic [63:0]  ll_in, lh_in, hl_in, hh_in, ll_ff, lh_ff, hl_ff, hh_ff;
   logic [127:0] prod_in, prod_ff;
   logic [63:0]  hi, lo, pmax;
   logic         neg, bad;

   assign ll_in = in_ma[31:0] * in_mb[31:0];
   assign lh_in = in_ma[31:0] * in_mb[63:32];
   assign hl_in = in_ma[63:32] * in_mb[31:0];
   assign hh_in = in_ma[63:32] * in_mb[63:32];

   assign prod_in = {64'd0, ll_ff} + {32'd0, lh_ff, 32'd0}
                  + {32'd0, hl_ff, 32'd0} + {hh_ff, 64'd0};

   always_comb begin
      hi   = prod_ff[127:64];
      lo   = prod_ff[63:0];
      pmax = {1'b0, product_max};
      neg  = (c2_ff.a_neg != c2_ff.b_neg) && (prod_ff != 128'd0);
      if (neg) begin
         bad = (hi != 64'd0) || (lo > SIGN_BIT);
      end else begin
         bad = (hi != 64'd0) || (lo > SIGN_BIT - 64'd1);
      end
      if (!neg && ((hi != 64'd0) || (lo > pmax))) begin
         bad = 1'b1;
      end
      if (product_min[63]) begin
         if (neg && ((hi != 64'd0) || (lo > 64'd0 - product_min))) begin
            bad = 1'b1;
         end
      end else begin
         if (neg || ((hi == 64'd0) && (lo < product_min))) begin
            bad = 1'b1;
         end
      end
      c3_in = c2_ff;
      if (opcode_type'(c2_ff.opcode) == OP_MUL) begin
         c3_in.value = neg ? (64'd0 - lo) : lo;
         c3_in.ovf   = bad;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
      if (adv) begin
         c1_ff   <= in_ctx;
         ma1_ff  <= in_ma;
         mb1_ff  <= in_mb;
         ll_ff   <= ll_in;
         lh_ff   <= lh_in;
         hl_ff   <= hl_in;
         hh_ff   <= hh_in;
         c2_ff   <= c1_ff;
         ma2_ff  <= ma1_ff;
         mb2_ff  <= mb1_ff;
         prod_ff <= prod_in;
         c3_ff   <= c3_in;
         ma3_ff  <= ma2_ff;
         mb3_ff  <= mb2_ff;
      end
   end

   assign out_valid = v3_ff;
   assign out_ctx   = c3_ff;
   assign out_ma    = ma3_ff;
   assign out_mb    = mb3_ff;

endmodule

### rtl/fxa_div.sv
// ---------------------------------------------------------------------------
// Fixnum ALU divider
// Restoring divider on magnitudes, one quotient bit per pipeline stage.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module fxa_div #(
   parameter int DATA_BITS = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 adv,
   input  logic                 in_valid,
   input  fxa_pkg::ctx_type     in_ctx,
   input  logic [63:0]          in_ma,
   input  logic [63:0]          in_mb,
   output logic                 out_valid,
   output fxa_pkg::ctx_type     out_ctx,
   output logic [DATA_BITS-1:0] quo,
   output logic [DATA_BITS-1:0] rem
);
   import fxa_pkg::*;

   localparam int W = DATA_BITS;

   logic         vld_src [W];
   ctx_type      ctx_src [W];
   logic [W-1:0] rem_src [W], quo_src [W], den_src [W];
   logic [W-1:0] rem_in  [W], quo_in  [W];
   logic         vld_ff  [W];
   ctx_type      ctx_ff  [W];
   logic [W-1:0] rem_ff  [W], quo_ff  [W], den_ff  [W];

   for (genvar g = 0; g < W; g++) begin : g_stage
      logic [W:0] trial;
      if (g == 0) begin : g_first
         assign vld_src[g] = in_valid;
         assign ctx_src[g] = in_ctx;
         assign rem_src[g] = '0;
         assign quo_src[g] = in_ma[W-1:0];
         assign den_src[g] = in_mb[W-1:0];
      end else begin : g_next
         assign vld_src[g] = vld_ff[g-1];
         assign ctx_src[g] = ctx_ff[g-1];
         assign rem_src[g] = rem_ff[g-1];
         assign quo_src[g] = quo_ff[g-1];
         assign den_src[g] = den_ff[g-1];
      end
      always_comb begin
         trial = {rem_src[g], quo_src[g][W-1]};
         if (trial >= {1'b0, den_src[g]}) begin
            rem_in[g] = W'(trial - {1'b0, den_src[g]});
            quo_in[g] = {quo_src[g][W-2:0], 1'b1};
         end else begin
            rem_in[g] = trial[W-1:0];
            quo_in[g] = {quo_src[g][W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < W; i++) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else if (adv) begin
            vld_ff[i] <= vld_src[i];
         end
         if (adv) begin
            ctx_ff[i] <= ctx_src[i];
            rem_ff[i] <= rem_in[i];
            quo_ff[i] <= quo_in[i];
            den_ff[i] <= den_src[i];
         end
      end
   end

   assign out_valid = vld_ff[W-1];
   assign out_ctx   = ctx_ff[W-1];
   assign quo       = quo_ff[W-1];
   assign rem       = rem_ff[W-1];

endmodule

### rtl/fxa_back.sv
// ---------------------------------------------------------------------------
// Fixnum ALU result stage
// Floor/truncate fix-up, divide-by-zero report, final wrap; output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module fxa_back #(
   parameter int DATA_BITS = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 adv,
   input  logic                 in_valid,
   input  fxa_pkg::ctx_type     in_ctx,
   input  logic [DATA_BITS-1:0] quo,
   input  logic [DATA_BITS-1:0] rem,
   output logic                 out_valid,
   output fxa_pkg::rsp_type     out_rsp
);
   import fxa_pkg::*;

   localparam logic [5:0]  MSB      = 6'(DATA_BITS - 1);
   localparam logic [63:0] SIGN_BIT = 64'd1 << (DATA_BITS - 1);

   logic [63:0] q64, rm64, r;
   logic        differ, ovf, err;
   logic        valid_ff;
   rsp_type     rsp_in, rsp_ff;

   always_comb begin
      q64    = 64'(quo);
      rm64   = 64'(rem);
      differ = in_ctx.a_neg != in_ctx.b_neg;
      r      = in_ctx.value;
      ovf    = in_ctx.ovf;
      err    = 1'b0;
      case (opcode_type'(in_ctx.opcode))
         OP_FLOORDIV: begin
            if (in_ctx.b_zero) begin
               r   = 64'd0;
               ovf = 1'b0;
               err = 1'b1;
            end else begin
               ovf = !differ && (q64 > SIGN_BIT - 64'd1);
               r   = differ ? (64'd0 - q64 - 64'(rm64 != 64'd0)) : q64;
            end
         end
         OP_REM: begin
            ovf = 1'b0;
            if (in_ctx.b_zero) begin
               r   = 64'd0;
               err = 1'b1;
            end else begin
               r = in_ctx.a_neg ? (64'd0 - rm64) : rm64;
            end
         end
         default: err = 1'b0;
      endcase
      rsp_in.result_value = sext_bits(r, MSB);
      rsp_in.overflow     = ovf;
      rsp_in.error_code   = err;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
      if (adv) begin
         rsp_ff <= rsp_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_rsp   = rsp_ff;

endmodule

### rtl/fixnum_alu_with_overflow_unit.sv
// ---------------------------------------------------------------------------
// Fixnum ALU with overflow
// Signed integer ALU: add/sub/mul/floordiv/rem/compare/logic/neg/abs.
// ---------------------------------------------------------------------------
// Usage:
//   req_* carries one operation beat (opcode, operand_a, operand_b) under
//   valid/ready; rsp_* returns exactly one beat per request, in order, with
//   the wrapped result, an overflow flag and a divide-by-zero error code.
//   csr_* writes product_min (index 0) and product_max (index 1), the range
//   a product must fall in to avoid the overflow flag; write only when idle.
// Pipeline: from request accept to response valid, each beat passes through
//   1 front stage, 3 multiplier stages, DATA_BITS divider stages (one
//   quotient bit each), 1 output register. Every opcode takes the same path.
// Throughput: one beat per cycle while not stalled; the whole pipe advances together.
// Stall: when rsp_valid is high and rsp_ready low the pipe freezes and
//   req_ready drops in the same cycle; nothing is dropped or repeated.
// Reset: synchronous; clears all valid bits and restores the product range
//   to the full signed 64-bit range.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module fixnum_alu_with_overflow_unit #(
   parameter int DATA_BITS = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  fxa_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output fxa_pkg::rsp_type rsp_data,
   input  logic             csr_wr_en,
   input  logic             csr_index,
   input  logic [63:0]      csr_wdata
);
   import fxa_pkg::*;

   logic                 adv;
   logic [63:0]          product_min_ff;
   logic [62:0]          product_max_ff;

   logic                 f_valid, m_valid, d_valid;
   ctx_type              f_ctx, m_ctx, d_ctx;
   logic [63:0]          f_ma, f_mb, m_ma, m_mb;
   logic [DATA_BITS-1:0] d_quo, d_rem;

   // global advance: move whenever the output register is free or drained
   assign adv       = !rsp_valid || rsp_ready;
   assign req_ready = adv;

   // range registers
   always_ff @(posedge clock) begin
      if (reset) begin
         product_min_ff <= 64'h8000_0000_0000_0000;
         product_max_ff <= '1;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_PRODUCT_MIN: product_min_ff <= csr_wdata;
            CSR_PRODUCT_MAX: product_max_ff <= csr_wdata[62:0];
            default:         product_min_ff <= product_min_ff;
         endcase
      end
   end

   fxa_front #(.DATA_BITS(DATA_BITS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req_valid),
      .req       (req_data),
      .out_valid (f_valid),
      .ctx       (f_ctx),
      .ma        (f_ma),
      .mb        (f_mb)
   );

   fxa_mul #(.DATA_BITS(DATA_BITS)) u_mul (
      .clock       (clock),
      .reset       (reset),
      .adv         (adv),
      .product_min (product_min_ff),
      .product_max (product_max_ff),
      .in_valid    (f_valid),
      .in_ctx      (f_ctx),
      .in_ma       (f_ma),
      .in_mb       (f_mb),
      .out_valid   (m_valid),
      .out_ctx     (m_ctx),
      .out_ma      (m_ma),
      .out_mb      (m_mb)
   );

   fxa_div #(.DATA_BITS(DATA_BITS)) u_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (m_valid),
      .in_ctx    (m_ctx),
      .in_ma     (m_ma),
      .in_mb     (m_mb),
      .out_valid (d_valid),
      .out_ctx   (d_ctx),
      .quo       (d_quo),
      .rem       (d_rem)
   );

   fxa_back #(.DATA_BITS(DATA_BITS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (d_valid),
      .in_ctx    (d_ctx),
      .quo       (d_quo),
      .rem       (d_rem),
      .out_valid (rsp_valid),
      .out_rsp   (rsp_data)
   );

endmodule

### rtl/fxa_checker.sv
// ---------------------------------------------------------------------------
// Fixnum ALU port checker
// Port-level assertions, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "fixnum_alu_with_overflow_unit_defines.svh"

module fxa_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input fxa_pkg::rsp_type rsp_data
);
   import fxa_pkg::*;

   // response held while stalled
   `FXA_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "rsp beat changed while stalled")

   // input side stalls exactly when the output register is blocked
   `FXA_ASSERT_NOW(a_ready_follows, 1'b1, req_ready == (!rsp_valid || rsp_ready), "req_ready does not track output stall")

   // a divide-by-zero beat carries zero and no overflow
   `FXA_ASSERT_NOW(a_err_clean, rsp_valid && rsp_data.error_code, rsp_data.result_value == 64'sd0 && !rsp_data.overflow, "error beat with nonzero result or overflow")

endmodule

bind fixnum_alu_with_overflow_unit fxa_checker u_fxa_checker (.*);
